[src/h2r_pkg.sv]
// ----------------------------------------------------------------------------
// h2r_pkg
// Shared widths, constants and types for the HSL to RGB converter.
// ----------------------------------------------------------------------------
package h2r_pkg;

    localparam int HUE_W  = 15;
    localparam int FRAC_W = 17;
    localparam int CHAN_W = 8;

    localparam int CN_W   = 33;   // chroma numerator, at most 2^32
    localparam int W_W    = 12;   // hue weight, at most 3840
    localparam int XP_W   = 44;   // chroma times weight
    localparam int M_W    = 34;   // offset numerator
    localparam int SUM_W  = 46;   // channel sum over 3840 * 2^33
    localparam int Q_W    = 13;   // sum * 255 >> 41, below 5745

    localparam logic [HUE_W-1:0]  HUE_SECTOR = 15'd3840;
    localparam logic [HUE_W-1:0]  HUE_PAIR   = 15'd7680;
    localparam logic [HUE_W-1:0]  HUE_SEC2   = 15'd11520;
    localparam logic [HUE_W-1:0]  HUE_SEC4   = 15'd15360;
    localparam logic [HUE_W-1:0]  HUE_SEC5   = 15'd19200;
    localparam logic [HUE_W-1:0]  HUE_FULL   = 15'd23040;

    localparam logic [FRAC_W-1:0] FRAC_ONE   = 17'd65536;
    localparam logic [FRAC_W-1:0] FRAC_HALF  = 17'd32768;
    localparam logic [FRAC_W:0]   FRAC_TWO   = 18'd131072;

    localparam logic [CN_W-1:0]   CN_MAX     = 33'h1_0000_0000;

    // floor(q / 15) == (q * 8739) >> 17 for every q below 10082
    localparam logic [13:0]       RECIP_15   = 14'd8739;
    localparam int                RECIP_SH   = 17;
    localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'd255;

    localparam logic [2:0] SEC_0 = 3'd0;
    localparam logic [2:0] SEC_1 = 3'd1;
    localparam logic [2:0] SEC_2 = 3'd2;
    localparam logic [2:0] SEC_3 = 3'd3;
    localparam logic [2:0] SEC_4 = 3'd4;
    localparam logic [2:0] SEC_5 = 3'd5;

    typedef enum logic [1:0] {
        TERM_ZERO,
        TERM_C,
        TERM_X
    } term_t;

    typedef struct packed {
        term_t            sel;
        logic [CN_W-1:0]  cn;
        logic [XP_W-1:0]  xp;
        logic [M_W-1:0]   m;
    } chan_in_t;

endpackage

[src/h2r_if.sv]
// ----------------------------------------------------------------------------
// h2r_if
// Valid/ready channels carrying HSL requests in and RGB results out.
// ----------------------------------------------------------------------------
interface h2r_hsl_if;
    logic                          valid;
    logic                          ready;
    logic [h2r_pkg::HUE_W-1:0]     hue;
    logic [h2r_pkg::FRAC_W-1:0]    saturation;
    logic [h2r_pkg::FRAC_W-1:0]    lightness;

    modport source (output valid, output hue, output saturation, output lightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input lightness,
                    output ready);
endinterface

interface h2r_rgb_if;
    logic                          valid;
    logic                          ready;
    logic [h2r_pkg::CHAN_W-1:0]    red;
    logic [h2r_pkg::CHAN_W-1:0]    green;
    logic [h2r_pkg::CHAN_W-1:0]    blue;

    modport source (output valid, output red, output green, output blue,
                    input ready);
    modport sink   (input valid, input red, input green, input blue,
                    output ready);
endinterface

[src/hsl_to_rgb_converter.sv]
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter
// Six register stages (clamp, chroma multiply, weight multiply, sum, scale,
// divide by 15) lie between request acceptance and result valid. Throughput:
// one request per cycle; a stall at the output freezes every stage. Reset
// clears only the stage valid bits.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter (
    input  logic        clk,
    input  logic        rst_n,
    h2r_hsl_if.sink     hsl,
    h2r_rgb_if.source   rgb
);

    localparam int STAGES = 6;

    logic [STAGES-1:0]             v_reg, v_next;
    logic                          adv;

    // stage 1
    logic [h2r_pkg::HUE_W-1:0]     hue1_reg, hue1_next;
    logic [h2r_pkg::FRAC_W-1:0]    sat1_reg, sat1_next;
    logic [h2r_pkg::FRAC_W-1:0]    lit1_reg, lit1_next;
    logic [h2r_pkg::FRAC_W-1:0]    a1_reg, a1_next;
    logic [h2r_pkg::FRAC_W:0]      twol, a_wide;

    // stage 2
    logic [h2r_pkg::CN_W-1:0]      cn2_reg, cn2_next;
    logic [h2r_pkg::W_W-1:0]       w2_reg, w2_next;
    logic [2:0]                    sec2_reg, sec2_next;
    logic [h2r_pkg::FRAC_W-1:0]    lit2_reg;
    logic [2*h2r_pkg::FRAC_W-1:0]  cn_full;
    logic [h2r_pkg::HUE_W-1:0]     pair_base, t_full, w_full;

    // stage 3
    h2r_pkg::chan_in_t             r3_reg, g3_reg, b3_reg;
    h2r_pkg::chan_in_t             r3_next, g3_next, b3_next;
    logic [h2r_pkg::CN_W+h2r_pkg::W_W-1:0] xp_full;
    logic [h2r_pkg::XP_W-1:0]      xp;
    logic [h2r_pkg::M_W-1:0]       m;
    h2r_pkg::term_t                sel_r, sel_g, sel_b;

    assign adv       = !v_reg[STAGES-1] || rgb.ready;
    assign hsl.ready = adv;
    assign rgb.valid = v_reg[STAGES-1];
    assign v_next    = {v_reg[STAGES-2:0], hsl.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= v_next;
    end

    // Stage 1: wrap hue, clamp fractions, 1 - |2L - 1|
    always_comb
    begin
        hue1_next = (hsl.hue >= h2r_pkg::HUE_FULL) ? hsl.hue - h2r_pkg::HUE_FULL : hsl.hue;
        sat1_next = (hsl.saturation > h2r_pkg::FRAC_ONE) ? h2r_pkg::FRAC_ONE
                                                          : hsl.saturation;
        lit1_next = (hsl.lightness > h2r_pkg::FRAC_ONE) ? h2r_pkg::FRAC_ONE
                                                         : hsl.lightness;
        twol      = {lit1_next, 1'b0};
        a_wide    = (lit1_next <= h2r_pkg::FRAC_HALF) ? twol : h2r_pkg::FRAC_TWO - twol;
        a1_next   = a_wide[h2r_pkg::FRAC_W-1:0];
    end

    // Stage 2: chroma product, sector and triangular hue weight
    always_comb
    begin
        cn_full  = a1_reg * sat1_reg;
        cn2_next = cn_full[h2r_pkg::CN_W-1:0];

        if (hue1_reg < h2r_pkg::HUE_SECTOR)
            sec2_next = h2r_pkg::SEC_0;
        else if (hue1_reg < h2r_pkg::HUE_PAIR)
            sec2_next = h2r_pkg::SEC_1;
        else if (hue1_reg < h2r_pkg::HUE_SEC2)
            sec2_next = h2r_pkg::SEC_2;
        else if (hue1_reg < h2r_pkg::HUE_SEC4)
            sec2_next = h2r_pkg::SEC_3;
        else if (hue1_reg < h2r_pkg::HUE_SEC5)
            sec2_next = h2r_pkg::SEC_4;
        else
            sec2_next = h2r_pkg::SEC_5;

        if (hue1_reg >= h2r_pkg::HUE_SEC4)
            pair_base = h2r_pkg::HUE_SEC4;
        else if (hue1_reg >= h2r_pkg::HUE_PAIR)
            pair_base = h2r_pkg::HUE_PAIR;
        else
            pair_base = '0;
        t_full  = hue1_reg - pair_base;
        w_full  = (t_full < h2r_pkg::HUE_SECTOR) ? t_full : h2r_pkg::HUE_PAIR - t_full;
        w2_next = w_full[h2r_pkg::W_W-1:0];
    end

    // Stage 3: chroma times weight, offset, per-channel selection
    always_comb
    begin
        xp_full = cn2_reg * w2_reg;
        xp      = xp_full[h2r_pkg::XP_W-1:0];
        m       = {lit2_reg, 17'b0} - h2r_pkg::M_W'(cn2_reg);

        unique case (sec2_reg)
            h2r_pkg::SEC_0:
            begin
                sel_r = h2r_pkg::TERM_C; sel_g = h2r_pkg::TERM_X; sel_b = h2r_pkg::TERM_ZERO;
            end
            h2r_pkg::SEC_1:
            begin
                sel_r = h2r_pkg::TERM_X; sel_g = h2r_pkg::TERM_C; sel_b = h2r_pkg::TERM_ZERO;
            end
            h2r_pkg::SEC_2:
            begin
                sel_r = h2r_pkg::TERM_ZERO; sel_g = h2r_pkg::TERM_C; sel_b = h2r_pkg::TERM_X;
            end
            h2r_pkg::SEC_3:
            begin
                sel_r = h2r_pkg::TERM_ZERO; sel_g = h2r_pkg::TERM_X; sel_b = h2r_pkg::TERM_C;
            end
            h2r_pkg::SEC_4:
            begin
                sel_r = h2r_pkg::TERM_X; sel_g = h2r_pkg::TERM_ZERO; sel_b = h2r_pkg::TERM_C;
            end
            default:
            begin
                sel_r = h2r_pkg::TERM_C; sel_g = h2r_pkg::TERM_ZERO; sel_b = h2r_pkg::TERM_X;
            end
        endcase

        r3_next = '{sel: sel_r, cn: cn2_reg, xp: xp, m: m};
        g3_next = '{sel: sel_g, cn: cn2_reg, xp: xp, m: m};
        b3_next = '{sel: sel_b, cn: cn2_reg, xp: xp, m: m};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hue1_reg <= hue1_next;
            sat1_reg <= sat1_next;
            lit1_reg <= lit1_next;
            a1_reg   <= a1_next;
            cn2_reg  <= cn2_next;
            w2_reg   <= w2_next;
            sec2_reg <= sec2_next;
            lit2_reg <= lit1_reg;
            r3_reg   <= r3_next;
            g3_reg   <= g3_next;
            b3_reg   <= b3_next;
        end
    end

    h2r_channel u_red (
        .clk   (clk),
        .en    (adv),
        .chan  (r3_reg),
        .level (rgb.red)
    );

    h2r_channel u_green (
        .clk   (clk),
        .en    (adv),
        .chan  (g3_reg),
        .level (rgb.green)
    );

    h2r_channel u_blue (
        .clk   (clk),
        .en    (adv),
        .chan  (b3_reg),
        .level (rgb.blue)
    );

    // A held result must block new requests
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (rgb.valid && !rgb.ready) |-> !hsl.ready)
        else $error("request taken while output stalled");

    // An accepted request occupies stage one next cycle
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (hsl.valid && hsl.ready) |=> v_reg[0])
        else $error("accepted request lost at stage one");

    // A stall freezes the whole valid chain
    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v_reg))
        else $error("valid chain moved during stall");

    a_chroma_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[1] |-> (cn2_reg <= h2r_pkg::CN_MAX))
        else $error("chroma numerator above one");

    a_weight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[1] |-> (w2_reg <= h2r_pkg::W_W'(h2r_pkg::HUE_SECTOR)))
        else $error("hue weight above one sector");

endmodule

[src/h2r_channel.sv]
// ----------------------------------------------------------------------------
// h2r_channel
// Last three stages of one colour channel: sum, scale by 255, divide by 15.
// ----------------------------------------------------------------------------
module h2r_channel (
    input  logic                          clk,
    input  logic                          en,
    input  h2r_pkg::chan_in_t             chan,
    output logic [h2r_pkg::CHAN_W-1:0]    level
);

    logic [h2r_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic [h2r_pkg::Q_W-1:0]     q_reg, q_next;
    logic [h2r_pkg::CHAN_W-1:0]  level_reg, level_next;

    logic [h2r_pkg::SUM_W-1:0]   term;
    logic [h2r_pkg::SUM_W-1:0]   cn_wide;
    logic [h2r_pkg::SUM_W-1:0]   m_wide;
    logic [h2r_pkg::SUM_W+7:0]   scaled;
    logic [h2r_pkg::SUM_W+7:0]   sum_wide;
    logic [h2r_pkg::Q_W+13:0]    prod;
    logic [9:0]                  quo;

    // Sum over 3840 * 2^33: 2 * term + 3840 * offset
    always_comb
    begin
        cn_wide = h2r_pkg::SUM_W'(chan.cn);
        m_wide  = h2r_pkg::SUM_W'(chan.m);
        case (chan.sel)
            h2r_pkg::TERM_C: term = (cn_wide << 13) - (cn_wide << 9);
            h2r_pkg::TERM_X: term = h2r_pkg::SUM_W'({chan.xp, 1'b0});
            default:         term = '0;
        endcase
        sum_next = term + (m_wide << 12) - (m_wide << 8);
    end

    // Times 255, then drop 2^41; 15 of the denominator remains
    always_comb
    begin
        sum_wide = (h2r_pkg::SUM_W + 8)'(sum_reg);
        scaled   = (sum_wide << 8) - sum_wide;
        q_next   = scaled[h2r_pkg::SUM_W+7 -: h2r_pkg::Q_W];
    end

    always_comb
    begin
        prod = q_reg * h2r_pkg::RECIP_15;
        quo  = prod[h2r_pkg::RECIP_SH +: 10];
        level_next = (quo > 10'(h2r_pkg::CHAN_MAX)) ? h2r_pkg::CHAN_MAX : quo[7:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg   <= sum_next;
            q_reg     <= q_next;
            level_reg <= level_next;
        end
    end

    assign level = level_reg;

endmodule

[tb/sv/tb_hsl_to_rgb_converter.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hsl_to_rgb_converter
// Drives HSL requests into the converter and compares every RGB result with
// an exact fixed-point prediction. A directed pass covers sector edges, the
// wrapped hue range, clamped fractions and the black/white corners. Random
// requests follow, with bursty idling on both channels.
// ----------------------------------------------------------------------------

class rgb_scoreboard;

    typedef struct packed {
        logic [h2r_pkg::CHAN_W-1:0] red;
        logic [h2r_pkg::CHAN_W-1:0] green;
        logic [h2r_pkg::CHAN_W-1:0] blue;
    } rgb_t;

    rgb_t expected_rgb[$];
    int   requests_seen;
    int   results_checked;
    int   errors;

    function new();
        requests_seen   = 0;
        results_checked = 0;
        errors          = 0;
    endfunction

    // (term + offset) * 255 over 3840 * 2^33, truncated, saturated at 255
    function logic [h2r_pkg::CHAN_W-1:0] scale_channel(bit [63:0] term, bit [63:0] offset);
        bit [63:0] denom;
        bit [63:0] v;
        denom = 64'd3840 << 33;
        v = ((term + offset) * h2r_pkg::CHAN_MAX) / denom;
        if (v > h2r_pkg::CHAN_MAX)
            v = h2r_pkg::CHAN_MAX;
        return v[h2r_pkg::CHAN_W-1:0];
    endfunction

    function rgb_t convert_hsl(logic [h2r_pkg::HUE_W-1:0]  h_in,
                               logic [h2r_pkg::FRAC_W-1:0] s_in,
                               logic [h2r_pkg::FRAC_W-1:0] l_in);
        bit [63:0] hue, sat, lit, twol, spread, chroma, phase, weight;
        bit [63:0] offset, cterm, xterm, rt, gt, bt;
        logic [2:0] sector;
        rgb_t res;
        hue = h_in;
        sat = (s_in > h2r_pkg::FRAC_ONE) ? h2r_pkg::FRAC_ONE : s_in;
        lit = (l_in > h2r_pkg::FRAC_ONE) ? h2r_pkg::FRAC_ONE : l_in;
        if (hue >= h2r_pkg::HUE_FULL)
            hue = hue - h2r_pkg::HUE_FULL;

        twol   = 2 * lit;
        spread = (twol >= h2r_pkg::FRAC_ONE) ? twol - h2r_pkg::FRAC_ONE
                                             : h2r_pkg::FRAC_ONE - twol;
        chroma = (h2r_pkg::FRAC_ONE - spread) * sat;

        // triangle weight over one 120 degree period, peak 3840 at mid-period
        phase  = hue % h2r_pkg::HUE_PAIR;
        weight = h2r_pkg::HUE_SECTOR - ((phase >= h2r_pkg::HUE_SECTOR)
                 ? phase - h2r_pkg::HUE_SECTOR : h2r_pkg::HUE_SECTOR - phase);

        offset = ((lit << 17) - chroma) * h2r_pkg::HUE_SECTOR;
        cterm  = 2 * chroma * h2r_pkg::HUE_SECTOR;
        xterm  = 2 * chroma * weight;

        sector = 3'(hue / h2r_pkg::HUE_SECTOR);
        case (sector)
            h2r_pkg::SEC_0:
            begin
                rt = cterm; gt = xterm; bt = 0;
            end
            h2r_pkg::SEC_1:
            begin
                rt = xterm; gt = cterm; bt = 0;
            end
            h2r_pkg::SEC_2:
            begin
                rt = 0;     gt = cterm; bt = xterm;
            end
            h2r_pkg::SEC_3:
            begin
                rt = 0;     gt = xterm; bt = cterm;
            end
            h2r_pkg::SEC_4:
            begin
                rt = xterm; gt = 0;     bt = cterm;
            end
            default:
            begin
                rt = cterm; gt = 0;     bt = xterm;
            end
        endcase

        res.red   = scale_channel(rt, offset);
        res.green = scale_channel(gt, offset);
        res.blue  = scale_channel(bt, offset);
        return res;
    endfunction

    function void note_request(logic [h2r_pkg::HUE_W-1:0]  h,
                               logic [h2r_pkg::FRAC_W-1:0] s,
                               logic [h2r_pkg::FRAC_W-1:0] l);
        expected_rgb.push_back(convert_hsl(h, s, l));
        requests_seen++;
    endfunction

    function void check_result(logic [h2r_pkg::CHAN_W-1:0] r,
                               logic [h2r_pkg::CHAN_W-1:0] g,
                               logic [h2r_pkg::CHAN_W-1:0] b);
        rgb_t exp;
        if (expected_rgb.size() == 0)
        begin
            $error("RGB result %0d/%0d/%0d with no request outstanding", r, g, b);
            errors++;
            return;
        end
        exp = expected_rgb.pop_front();
        results_checked++;
        if (r !== exp.red)
        begin
            $error("red mismatch: expected %0d, actual %0d", exp.red, r);
            errors++;
        end
        if (g !== exp.green)
        begin
            $error("green mismatch: expected %0d, actual %0d", exp.green, g);
            errors++;
        end
        if (b !== exp.blue)
        begin
            $error("blue mismatch: expected %0d, actual %0d", exp.blue, b);
            errors++;
        end
    endfunction

endclass

module tb_hsl_to_rgb_converter;

    localparam int RANDOM_REQUESTS = 750;
    localparam int QUIET_TAIL      = 150;
    localparam int DRAIN_CYCLES    = 24;
    localparam int CYCLE_LIMIT     = 200000;

    logic clk;
    logic rst_n;
    bit   idle_on;
    int unsigned cycles = 0;
    int   stall_left;

    rgb_scoreboard sb;

    h2r_hsl_if hsl ();
    h2r_rgb_if rgb ();

    hsl_to_rgb_converter dut (
        .clk   (clk),
        .rst_n (rst_n),
        .hsl   (hsl),
        .rgb   (rgb)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result channel: check on every accepted result
    always @(posedge clk)
    begin
        if (rst_n && rgb.valid && rgb.ready)
            sb.check_result(rgb.red, rgb.green, rgb.blue);
    end

    // result back-pressure in bursts of random length
    initial
    begin
        rgb.ready  = 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                rgb.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 5) - 1;
                rgb.ready <= 1'b0;
            end
            else
                rgb.ready <= 1'b1;
        end
    end

    // entered and left at a falling edge
    task automatic send_request(input logic [h2r_pkg::HUE_W-1:0]  h,
                                input logic [h2r_pkg::FRAC_W-1:0] s,
                                input logic [h2r_pkg::FRAC_W-1:0] l);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            hsl.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        hsl.valid      <= 1'b1;
        hsl.hue        <= h;
        hsl.saturation <= s;
        hsl.lightness  <= l;
        @(posedge clk);
        while (!hsl.ready)
            @(posedge clk);
        sb.note_request(h, s, l);
        @(negedge clk);
    endtask

    function automatic logic [h2r_pkg::FRAC_W-1:0] pick_fraction();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return h2r_pkg::FRAC_ONE;
            2:       return h2r_pkg::FRAC_W'($urandom_range(32'd65537, 32'd131071));
            default: return h2r_pkg::FRAC_W'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [h2r_pkg::HUE_W-1:0] pick_hue();
        int k;
        case ($urandom_range(0, 9))
            0:
            begin
                // either side of a sector edge
                k = $urandom_range(1, 6);
                return h2r_pkg::HUE_W'(k * 3840 - $urandom_range(0, 1));
            end
            1:       return h2r_pkg::HUE_W'($urandom_range(23040, 32767));
            default: return h2r_pkg::HUE_W'($urandom_range(0, 23039));
        endcase
    endfunction

    task automatic run_directed();
        logic [h2r_pkg::HUE_W-1:0] edge_hues [13];
        edge_hues = '{15'd0, 15'd1, 15'd3839, 15'd3840, 15'd7679, 15'd7680, 15'd11520,
                      15'd15360, 15'd19199, 15'd19200, 15'd23039, 15'd23040, 15'd32767};
        // fully saturated mid-grey sweeps all six sectors and the wrapped range
        foreach (edge_hues[i])
            send_request(edge_hues[i], h2r_pkg::FRAC_ONE, h2r_pkg::FRAC_HALF);
        send_request(15'd0,     17'd0,             17'd0);
        send_request(15'd0,     17'd0,             h2r_pkg::FRAC_ONE);
        send_request(15'd5000,  17'd131071,        h2r_pkg::FRAC_HALF);
        send_request(15'd9000,  h2r_pkg::FRAC_ONE, 17'd131071);
        send_request(15'd1920,  17'd65535,         17'd65535);
        send_request(15'd13440, h2r_pkg::FRAC_ONE, 17'd1);
        send_request(15'd21000, 17'd21845,         17'd43690);
        send_request(15'd17000, 17'd65537,         17'd65537);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        idle_on        = 1'b1;
        hsl.valid      = 1'b0;
        hsl.hue        = '0;
        hsl.saturation = '0;
        hsl.lightness  = '0;
        sb = new();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed();

        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            // stretches without idling, and none at all in the tail
            idle_on = (i < RANDOM_REQUESTS - QUIET_TAIL) && ((i / 100) % 3 != 2);
            send_request(pick_hue(), pick_fraction(), pick_fraction());
        end
        hsl.valid <= 1'b0;

        while (sb.expected_rgb.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.expected_rgb.size() != 0)
        begin
            $error("%0d RGB results never arrived", sb.expected_rgb.size());
            sb.errors++;
        end

        $display("Sent %0d HSL requests and compared %0d RGB results,", sb.requests_seen,
                 sb.results_checked);
        $display("covering all six sectors, wrapped hues and clamped fractions.");
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
